// ===== rtl/alfl_pkg.sv =====
// ============================================================================
// alfl_pkg
// Shared constants, types and helpers for the array linked list / free list.
// ============================================================================
package alfl_pkg;

    localparam int NUM_NODES  = 128;
    localparam int IDX_W      = $clog2(NUM_NODES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int VALUE_W    = 32;
    localparam int SLOT_W     = 7;
    localparam int STATUS_W   = 2;

    // null link is one past the last node
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_NODES);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_val_en;
        logic               wr_link_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [VALUE_W-1:0] wr_val;
        logic [LINK_W-1:0]  wr_link;
    } t_node_req;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LINK_W-1:0]  link;
    } t_node_rsp;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_NULL;
    endfunction

endpackage

// ===== rtl/alfl_ram.sv =====
// ============================================================================
// alfl_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module alfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/alfl_store.sv =====
// ============================================================================
// alfl_store
// Node store: value RAM and link RAM read at one address per cycle. A fill
// count stands in for the reset chain of the link RAM.
// ============================================================================
module alfl_store
    import alfl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_node_req i_req,
    output t_node_rsp o_rsp
);

    // nodes at or above the fill count were never written: link is index + 1
    logic [LINK_W-1:0]  r_fill, n_fill;
    logic               r_rd_fresh;
    logic [IDX_W-1:0]   r_rd_addr;
    logic [VALUE_W-1:0] ram_value;
    logic [LINK_W-1:0]  ram_link;
    logic [LINK_W-1:0]  rd_link;
    logic [LINK_W-1:0]  rd_addr_ext;
    logic [LINK_W-1:0]  wr_addr_ext;

    assign rd_addr_ext = {1'b0, i_req.rd_addr};
    assign wr_addr_ext = {1'b0, i_req.wr_addr};

    alfl_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_NODES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_val_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_val),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_value)
    );

    alfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_link_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_link),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_link)
    );

    always_comb begin
        n_fill = r_fill;
        if (i_req.wr_link_en && (wr_addr_ext >= r_fill)) begin
            n_fill = wr_addr_ext + LINK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_fresh <= rd_addr_ext >= r_fill;
            r_rd_addr  <= i_req.rd_addr;
        end
    end

    assign rd_link = r_rd_fresh ? ({1'b0, r_rd_addr} + LINK_W'(1)) : ram_link;
    assign o_rsp   = {ram_value, rd_link};

endmodule

// ===== rtl/array_linked_list_free_list_unit.sv =====
// ============================================================================
// array_linked_list_free_list_unit
// Linked list with free list kept in a node store; insert at head, remove
// first match by walking the list one node per cycle.
// ============================================================================
// Full and empty-list commands answer straight from S_IDLE, insert through
// S_INS; remove walks in S_WALK and answers not found from there, or on a
// match passes through S_UNLINK. One command at a time; the walk reads one
// node per cycle through the node store read port. Results cannot be
// stalled. Synchronous reset: empty list, all nodes free in index order at
// once (fill count, no clearing pass).
module array_linked_list_free_list_unit
    import alfl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_strobe,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_W-1:0]          o_slot
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_INS    = 4'b0010,
        S_WALK   = 4'b0100,
        S_UNLINK = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [LINK_W-1:0]   r_list_head, n_list_head;
    logic [LINK_W-1:0]   r_free_head, n_free_head;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [LINK_W-1:0]   r_prev, n_prev;
    logic [LINK_W-1:0]   r_steps, n_steps;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                accept;
    logic [LINK_W-1:0]   steps_inc;
    t_node_req           req;
    t_node_rsp           rsp;

    alfl_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign steps_inc = r_steps + LINK_W'(1);

    always_comb begin
        n_state     = r_state;
        n_list_head = r_list_head;
        n_free_head = r_free_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_value     = r_value;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        req         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value = $unsigned(i_value);
                    if (i_cmd == CMD_INSERT) begin
                        if (!link_ok(r_free_head)) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                            n_slot   = '0;
                        end else begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = r_free_head[IDX_W-1:0];
                            n_cur       = r_free_head;
                            n_state     = S_INS;
                        end
                    end else begin
                        if (!link_ok(r_list_head)) begin
                            n_strobe = 1'b1;
                            n_status = ST_NOT_FOUND;
                            n_slot   = '0;
                        end else begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = r_list_head[IDX_W-1:0];
                            n_cur       = r_list_head;
                            n_prev      = LINK_NULL;
                            n_steps     = '0;
                            n_state     = S_WALK;
                        end
                    end
                end
            end
            S_INS: begin
                // rsp.link is the next free node
                req.wr_val_en  = 1'b1;
                req.wr_link_en = 1'b1;
                req.wr_addr    = r_cur[IDX_W-1:0];
                req.wr_val     = r_value;
                req.wr_link    = r_list_head;
                n_list_head    = r_cur;
                n_free_head    = rsp.link;
                n_strobe       = 1'b1;
                n_status       = ST_INSERTED;
                n_slot         = SLOT_W'(r_cur);
                n_state        = S_IDLE;
            end
            S_WALK: begin
                if (rsp.value == r_value) begin
                    if (link_ok(r_prev)) begin
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_prev[IDX_W-1:0];
                        req.wr_link    = rsp.link;
                    end else begin
                        n_list_head = rsp.link;
                    end
                    n_state = S_UNLINK;
                end else if (!link_ok(rsp.link) || (steps_inc >= LINK_W'(NUM_NODES))) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_slot   = '0;
                    n_state  = S_IDLE;
                end else begin
                    // next node address straight from the link read beat
                    req.rd_en   = 1'b1;
                    req.rd_addr = rsp.link[IDX_W-1:0];
                    n_prev      = r_cur;
                    n_cur       = rsp.link;
                    n_steps     = steps_inc;
                end
            end
            S_UNLINK: begin
                req.wr_link_en = 1'b1;
                req.wr_addr    = r_cur[IDX_W-1:0];
                req.wr_link    = r_free_head;
                n_free_head    = r_cur;
                n_strobe       = 1'b1;
                n_status       = ST_REMOVED;
                n_slot         = SLOT_W'(r_cur);
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_head <= LINK_NULL;
            r_free_head <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_value  <= n_value;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    // every accepted command either answers at once or goes busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_strobe || busy))
        else $error("accepted command neither answered nor started");

    // the walk never runs past the node count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps < LINK_W'(NUM_NODES)))
        else $error("list walk exceeded node count");

    // reads and writes to the node store never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.rd_en && (req.wr_link_en || req.wr_val_en)))
        else $error("node store read and write in same cycle");

    // full and not found carry slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_status == ST_FULL) || (o_status == ST_NOT_FOUND)))
            |-> (o_slot == '0))
        else $error("failed command with nonzero slot");

    // a result beat always ends the busy period
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

endmodule
